// ----- design/flash_pool_region_allocator_defines.svh -----
// Assertion macros shared by the allocator checker.
// No dependencies; include by bare file name.
`ifndef FLASH_POOL_REGION_ALLOCATOR_DEFINES_SVH
`define FLASH_POOL_REGION_ALLOCATOR_DEFINES_SVH

// Checked on every edge outside reset.
`define FPRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define FPRA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/fpra_pkg.sv -----
// Shared types, constants and helpers for the flash pool region allocator.
// No dependencies.
package fpra_pkg;

  localparam int MAX_REGIONS = 8;
  localparam int ALIGN_BYTES = 65536;

  localparam int ADDR_W   = 24;
  localparam int SIZE_W   = 25;
  localparam int APP_W    = 4;
  localparam int STATUS_W = 3;
  localparam int CNT_W    = 4;
  localparam int CFG_W    = 1;
  localparam int IDX_W    = $clog2(MAX_REGIONS);
  localparam int CUR_W    = SIZE_W + 1;
  localparam int ALIGN_W  = $clog2(ALIGN_BYTES);

  localparam logic [ADDR_W-1:0] POOL_START_RST = 24'h92_0000;
  localparam logic [ADDR_W-1:0] POOL_END_RST   = 24'hF2_0000;

  localparam logic [CFG_W-1:0] CFG_POOL_START = 1'b0;
  localparam logic [CFG_W-1:0] CFG_POOL_END   = 1'b1;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_FULL      = 3'd2,
    ST_NO_GAP    = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] length;
    logic [APP_W-1:0]  app;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } tbl_ctl_t;

  typedef struct packed {
    logic [SIZE_W-1:0] gap;
    logic [CUR_W-1:0]  cursor;
  } gap_step_t;

  function automatic logic [SIZE_W-1:0] align_up(input logic [SIZE_W-1:0] sz);
    logic [CUR_W-1:0] sum;
    sum = {1'b0, sz} + CUR_W'(ALIGN_BYTES - 1);
    sum[ALIGN_W-1:0] = '0;
    return sum[SIZE_W-1:0];
  endfunction

endpackage

// ----- design/fpra_table.sv -----
// Region table: one write port, one registered read port, write-to-read bypass.
// Depends on fpra_pkg.
module fpra_table (
  input  logic              clk,
  input  fpra_pkg::tbl_ctl_t ctl,
  output fpra_pkg::entry_t  rdata
);

  fpra_pkg::entry_t mem [fpra_pkg::MAX_REGIONS];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
    if (ctl.we && ctl.waddr == ctl.raddr) begin
      rdata <= ctl.wdata;
    end else begin
      rdata <= mem[ctl.raddr];
    end
  end

endmodule

// ----- design/fpra_gap.sv -----
// One step of the gap walk: free span from cursor to a limit clipped at pool_end,
// and the cursor advanced past a region. Depends on fpra_pkg.
module fpra_gap (
  input  logic [fpra_pkg::CUR_W-1:0]  cursor,
  input  logic [fpra_pkg::ADDR_W-1:0] limit,
  input  logic [fpra_pkg::ADDR_W-1:0] pool_end,
  input  logic [fpra_pkg::CUR_W-1:0]  region_end,
  output fpra_pkg::gap_step_t         step
);

  logic [fpra_pkg::ADDR_W-1:0] stop;
  logic [fpra_pkg::CUR_W-1:0]  stop_ext;
  logic [fpra_pkg::CUR_W-1:0]  diff;

  always_comb begin
    stop     = (limit < pool_end) ? limit : pool_end;
    stop_ext = {2'b00, stop};
    diff     = stop_ext - cursor;
    step.gap = (stop_ext > cursor) ? diff[fpra_pkg::SIZE_W-1:0] : '0;
    // cursor never moves backward
    step.cursor = (region_end > cursor) ? region_end : cursor;
  end

endmodule

// ----- design/flash_pool_region_allocator.sv -----
// Flash pool region allocator: a start/busy command port for add and remove
// requests, a one-cycle done strobe carrying the result, and a write-only
// configuration port for the pool bounds. Regions live in a small table memory
// with one read and one write per cycle; every request walks that table one
// entry a cycle (add: fit scan, shift up, gap scan; remove: search, shift down,
// gap scan with renumbering). The done strobe cannot be stalled: sample the
// result fields in the cycle done is high. busy is low in that same cycle, so
// the next start may be issued there. Pool bounds may only be written while
// busy is low. Depends on fpra_pkg, fpra_table, fpra_gap.
module flash_pool_region_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          opcode,
  input  logic [fpra_pkg::SIZE_W-1:0]   req_bytes,
  input  logic [fpra_pkg::ADDR_W-1:0]   region_address,
  output logic                          done,
  output logic [fpra_pkg::STATUS_W-1:0] status,
  output logic [fpra_pkg::ADDR_W-1:0]   placed_offset,
  output logic [fpra_pkg::SIZE_W-1:0]   placed_size,
  output logic [fpra_pkg::APP_W-1:0]    app_number,
  output logic [fpra_pkg::CNT_W-1:0]    region_count,
  output logic [fpra_pkg::SIZE_W-1:0]   largest_gap,
  input  logic                          cfg_write,
  input  logic [fpra_pkg::CFG_W-1:0]    cfg_index,
  input  logic [fpra_pkg::ADDR_W-1:0]   cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_FIT      = 6'b000010,
    S_SHIFT_UP = 6'b000100,
    S_FIND     = 6'b001000,
    S_SHIFT_DN = 6'b010000,
    S_GAP      = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [fpra_pkg::CNT_W-1:0]    idx, idx_next;
  logic [fpra_pkg::CNT_W-1:0]    total, total_next;
  logic [fpra_pkg::CNT_W-1:0]    pos, pos_next;
  logic [fpra_pkg::SIZE_W-1:0]   size_al, size_al_next;
  logic [fpra_pkg::ADDR_W-1:0]   addr, addr_next;
  logic [fpra_pkg::CUR_W-1:0]    cursor, cursor_next;
  logic [fpra_pkg::SIZE_W-1:0]   best, best_next;
  logic                          renum, renum_next;
  logic [fpra_pkg::ADDR_W-1:0]   pool_start, pool_end;

  logic [fpra_pkg::STATUS_W-1:0] status_next;
  logic [fpra_pkg::ADDR_W-1:0]   placed_offset_next;
  logic [fpra_pkg::SIZE_W-1:0]   placed_size_next;
  logic [fpra_pkg::APP_W-1:0]    app_number_next;
  logic [fpra_pkg::CNT_W-1:0]    region_count_next;
  logic [fpra_pkg::SIZE_W-1:0]   largest_gap_next;
  logic                          done_next;

  fpra_pkg::tbl_ctl_t            tbl;
  fpra_pkg::entry_t              rdata;
  fpra_pkg::gap_step_t           step;
  logic                          in_range;
  logic [fpra_pkg::ADDR_W-1:0]   limit;
  logic [fpra_pkg::CUR_W-1:0]    region_end;
  logic [fpra_pkg::ADDR_W-1:0]   span;
  logic [fpra_pkg::CNT_W-1:0]    raddr_full;
  logic [fpra_pkg::CUR_W-1:0]    pool_start_ext;

  fpra_table u_table (
    .clk   (clk),
    .ctl   (tbl),
    .rdata (rdata)
  );

  fpra_gap u_gap (
    .cursor     (cursor),
    .limit      (limit),
    .pool_end   (pool_end),
    .region_end (region_end),
    .step       (step)
  );

  assign busy           = (state != S_IDLE);
  assign in_range       = (idx < total);
  assign limit          = in_range ? rdata.start : pool_end;
  assign region_end     = {2'b00, rdata.start} + {1'b0, rdata.length};
  assign span           = (pool_end > pool_start) ? (pool_end - pool_start) : '0;
  assign pool_start_ext = {2'b00, pool_start};

  always_comb begin
    state_next         = state;
    idx_next           = idx;
    total_next         = total;
    pos_next           = pos;
    size_al_next       = size_al;
    addr_next          = addr;
    cursor_next        = cursor;
    best_next          = best;
    renum_next         = renum;
    status_next        = status;
    placed_offset_next = placed_offset;
    placed_size_next   = placed_size;
    app_number_next    = app_number;
    region_count_next  = region_count;
    largest_gap_next   = largest_gap;
    done_next          = 1'b0;
    tbl.we             = 1'b0;
    tbl.waddr          = idx[fpra_pkg::IDX_W-1:0];
    tbl.wdata          = rdata;

    case (state)
      S_IDLE: begin
        if (start) begin
          status_next        = fpra_pkg::ST_OK;
          placed_offset_next = '0;
          placed_size_next   = '0;
          app_number_next    = '0;
          idx_next           = '0;
          cursor_next        = pool_start_ext;
          best_next          = '0;
          renum_next         = 1'b0;
          addr_next          = region_address;
          if (opcode == fpra_pkg::OP_ADD) begin
            if (total >= fpra_pkg::CNT_W'(fpra_pkg::MAX_REGIONS)) begin
              status_next = fpra_pkg::ST_FULL;
              state_next  = S_GAP;
            end else if (req_bytes == '0 || req_bytes > {1'b0, span}) begin
              status_next = fpra_pkg::ST_BAD_SIZE;
              state_next  = S_GAP;
            end else begin
              size_al_next = fpra_pkg::align_up(req_bytes);
              state_next   = S_FIT;
            end
          end else begin
            state_next = S_FIND;
          end
        end
      end

      S_FIT: begin
        // past the last region the limit is pool_end itself
        if (step.gap >= size_al) begin
          pos_next   = idx;
          idx_next   = total;
          state_next = S_SHIFT_UP;
        end else if (in_range) begin
          cursor_next = step.cursor;
          idx_next    = idx + 1'b1;
        end else begin
          status_next = fpra_pkg::ST_NO_GAP;
          idx_next    = '0;
          cursor_next = pool_start_ext;
          state_next  = S_GAP;
        end
      end

      S_SHIFT_UP: begin
        tbl.we = 1'b1;
        if (idx > pos) begin
          idx_next = idx - 1'b1;
        end else begin
          tbl.wdata.start    = cursor[fpra_pkg::ADDR_W-1:0];
          tbl.wdata.length   = size_al;
          tbl.wdata.app      = total[fpra_pkg::APP_W-1:0];
          total_next         = total + 1'b1;
          placed_offset_next = cursor[fpra_pkg::ADDR_W-1:0];
          placed_size_next   = size_al;
          app_number_next    = total[fpra_pkg::APP_W-1:0];
          idx_next           = '0;
          cursor_next        = pool_start_ext;
          state_next         = S_GAP;
        end
      end

      S_FIND: begin
        if (in_range && rdata.start == addr) begin
          state_next = S_SHIFT_DN;
        end else if (in_range) begin
          idx_next = idx + 1'b1;
        end else begin
          status_next = fpra_pkg::ST_NOT_FOUND;
          idx_next    = '0;
          cursor_next = pool_start_ext;
          state_next  = S_GAP;
        end
      end

      S_SHIFT_DN: begin
        if (idx + 1'b1 < total) begin
          tbl.we   = 1'b1;
          idx_next = idx + 1'b1;
        end else begin
          total_next  = total - 1'b1;
          renum_next  = 1'b1;
          idx_next    = '0;
          cursor_next = pool_start_ext;
          state_next  = S_GAP;
        end
      end

      S_GAP: begin
        if (in_range) begin
          best_next   = (step.gap > best) ? step.gap : best;
          cursor_next = step.cursor;
          idx_next    = idx + 1'b1;
          // after a remove, renumber in offset order on the same pass
          if (renum) begin
            tbl.we        = 1'b1;
            tbl.wdata.app = idx[fpra_pkg::APP_W-1:0];
          end
        end else begin
          largest_gap_next  = (step.gap > best) ? step.gap : best;
          region_count_next = total;
          done_next         = 1'b1;
          state_next        = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // read address is taken from the next index to match the registered read
    case (state_next)
      S_SHIFT_UP: raddr_full = idx_next - 1'b1;
      S_SHIFT_DN: raddr_full = idx_next + 1'b1;
      default:    raddr_full = idx_next;
    endcase
    tbl.raddr = raddr_full[fpra_pkg::IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      total      <= '0;
      done       <= 1'b0;
      renum      <= 1'b0;
      pool_start <= fpra_pkg::POOL_START_RST;
      pool_end   <= fpra_pkg::POOL_END_RST;
    end else begin
      state <= state_next;
      total <= total_next;
      done  <= done_next;
      renum <= renum_next;
      if (cfg_write) begin
        case (cfg_index)
          fpra_pkg::CFG_POOL_START: pool_start <= cfg_data;
          fpra_pkg::CFG_POOL_END:   pool_end   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx           <= idx_next;
    pos           <= pos_next;
    size_al       <= size_al_next;
    addr          <= addr_next;
    cursor        <= cursor_next;
    best          <= best_next;
    status        <= status_next;
    placed_offset <= placed_offset_next;
    placed_size   <= placed_size_next;
    app_number    <= app_number_next;
    region_count  <= region_count_next;
    largest_gap   <= largest_gap_next;
  end

endmodule

// ----- design/fpra_checker.sv -----
// Port-level checks for the flash pool region allocator, bound to the top level.
// Depends on fpra_pkg and flash_pool_region_allocator_defines.svh.
`include "flash_pool_region_allocator_defines.svh"

module fpra_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [fpra_pkg::STATUS_W-1:0] status,
  input logic [fpra_pkg::ADDR_W-1:0]   placed_offset,
  input logic [fpra_pkg::SIZE_W-1:0]   placed_size,
  input logic [fpra_pkg::APP_W-1:0]    app_number,
  input logic [fpra_pkg::CNT_W-1:0]    region_count
);

  `FPRA_ASSERT_ALWAYS(a_reset_quiet, rst |=> (!busy && !done), "busy or done right after reset")
  `FPRA_ASSERT(a_start_busy, (start && !busy) |=> busy, "transfer accepted but block not busy")
  `FPRA_ASSERT(a_done_idle, done |-> !busy, "result strobe while still busy")
  `FPRA_ASSERT(a_count_max, done |-> (region_count <= fpra_pkg::CNT_W'(fpra_pkg::MAX_REGIONS)), "region count over table depth")
  `FPRA_ASSERT(a_fail_zero, (done && status != fpra_pkg::ST_OK) |-> (placed_offset == '0 && placed_size == '0 && app_number == '0), "placement fields set on a failed request")

endmodule

bind flash_pool_region_allocator fpra_checker u_fpra_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .status        (status),
  .placed_offset (placed_offset),
  .placed_size   (placed_size),
  .app_number    (app_number),
  .region_count  (region_count)
);
